### rtl/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg - shared types and constants
// Field widths, request codes, register map and the cell control struct.
// ----------------------------------------------------------------------------
package tmb_pkg;

  // field widths
  localparam int STAMP_W     = 64;
  localparam int HANDLE_W    = 32;
  localparam int REQ_W       = 2;
  localparam int REMOVED_W   = 6;
  localparam int MAXE_W      = 6;

  // configuration port
  localparam int PDATA_W     = 64;
  localparam int PADDR_W     = 4;
  localparam int ADDR_SEL_BIT = 3;   // registers sit on 8-byte boundaries

  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_MATCH_TOL   = 1'b1;

  localparam logic [MAXE_W-1:0] MAXE_RESET = 6'd25;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

  // per-cell control: shift towards the head, or load the write data
  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

endpackage

### rtl/tmb_in_if.sv
// ----------------------------------------------------------------------------
// tmb_in_if - request channel
// Valid/ready channel carrying one buffer request.
// ----------------------------------------------------------------------------
interface tmb_in_if;
  logic                           valid;
  logic                           ready;
  logic [tmb_pkg::REQ_W-1:0]      req_type;
  logic [tmb_pkg::STAMP_W-1:0]    time_ns;
  logic [tmb_pkg::HANDLE_W-1:0]   frame_handle;

  modport source (output valid, output req_type, output time_ns, output frame_handle,
                  input ready);
  modport sink   (input valid, input req_type, input time_ns, input frame_handle,
                  output ready);
endinterface

### rtl/tmb_out_if.sv
// ----------------------------------------------------------------------------
// tmb_out_if - result channel
// Valid/ready channel carrying one request result.
// ----------------------------------------------------------------------------
interface tmb_out_if;
  logic                            valid;
  logic                            ready;
  logic                            handle_valid;
  logic [tmb_pkg::HANDLE_W-1:0]    result_handle;
  logic [tmb_pkg::REMOVED_W-1:0]   removed_count;

  modport source (output valid, output handle_valid, output result_handle,
                  output removed_count, input ready);
  modport sink   (input valid, input handle_valid, input result_handle,
                  input removed_count, output ready);
endinterface

### rtl/timestamp_match_buffer.sv
// ----------------------------------------------------------------------------
// timestamp_match_buffer - arrival-ordered frame handle buffer
// Add / remove-at-or-before / find-in-window over a row of stamp cells.
// ----------------------------------------------------------------------------
//
//   channel   ports          direction  transfer carries
//   --------  -------------  ---------  ---------------------------------------
//   request   in_chan        in         req_type, time_ns, frame_handle
//   result    out_chan       out        handle_valid, result_handle, removed_count
//   config    psel..pready   in/out     max_entries @0x0, match_tolerance @0x8
//
// Sequence: add passes through ST_ADD then ST_DONE; remove and find step through
//   ST_SCAN once per entry (straight to ST_DONE when empty), then ST_DONE: one
//   entry passes the head compare per cycle while the row rotates or compacts.
// One request is in flight at a time; the next is taken once the result has
//   moved into the output register, which then waits for out_chan.ready.
// Reset (synchronous, rst_n low) empties the buffer and restores the register
//   defaults; the cell contents are not cleared.
// ----------------------------------------------------------------------------
module timestamp_match_buffer #(
  parameter int DEPTH       = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tmb_in_if.sink                        in_chan,
  tmb_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmb_pkg::PADDR_W-1:0]   paddr,
  input  logic [tmb_pkg::PDATA_W-1:0]   pwdata,
  output logic [tmb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CW = $clog2(DEPTH + 1);   // holds 0..DEPTH
  localparam int IW = $clog2(DEPTH);       // cell index
  localparam int HW = (HANDLE_BITS < tmb_pkg::HANDLE_W) ? HANDLE_BITS : tmb_pkg::HANDLE_W;
  localparam int LW = (CW > tmb_pkg::MAXE_W) ? CW : tmb_pkg::MAXE_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_SCAN, ST_DONE} state_t;

  // control / request registers
  state_t                          state_r;
  logic [CW-1:0]                   count_r;
  logic [CW-1:0]                   scan_r;
  logic [tmb_pkg::REQ_W-1:0]       req_r;
  logic [tmb_pkg::STAMP_W-1:0]     time_r;
  logic [HW-1:0]                   hnd_r;
  logic [tmb_pkg::STAMP_W-1:0]     lo_r;
  logic [tmb_pkg::STAMP_W-1:0]     hi_r;
  logic                            found_r;
  logic [HW-1:0]                   res_hnd_r;
  logic [CW-1:0]                   removed_r;

  // output register
  logic                            out_valid_r;
  logic                            out_hv_r;
  logic [tmb_pkg::HANDLE_W-1:0]    out_hnd_r;
  logic [tmb_pkg::REMOVED_W-1:0]   out_rem_r;

  // configuration registers
  logic [tmb_pkg::MAXE_W-1:0]      max_r;
  logic [tmb_pkg::STAMP_W-1:0]     tol_r;

  // cell row
  logic [tmb_pkg::STAMP_W-1:0]     stamp_w [DEPTH];
  logic [HW-1:0]                   hnd_w   [DEPTH];
  tmb_pkg::cell_ctrl_t             ctrl_w  [DEPTH];

  logic                            shift;
  logic                            wr_en;
  logic [IW-1:0]                   wr_idx;
  logic [tmb_pkg::STAMP_W-1:0]     wr_stamp;
  logic [HW-1:0]                   wr_hnd;

  logic                            accept;
  logic                            cfg_wr;
  logic                            evict;
  logic                            kept;
  logic                            in_win;
  logic [CW-1:0]                   count_m1;
  logic [tmb_pkg::STAMP_W-1:0]     lo_calc;
  logic [tmb_pkg::STAMP_W:0]       hi_sum;
  logic [tmb_pkg::STAMP_W-1:0]     hi_calc;

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.handle_valid  = out_hv_r;
  assign out_chan.result_handle = out_hnd_r;
  assign out_chan.removed_count = out_rem_r;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[tmb_pkg::ADDR_SEL_BIT] ? tol_r : tmb_pkg::PDATA_W'(max_r);

  // --------------------------------------------------------------------------
  // find window, saturating at both ends; worked out on the request transfer
  // --------------------------------------------------------------------------
  assign lo_calc = (in_chan.time_ns >= tol_r) ? (in_chan.time_ns - tol_r) : '0;
  assign hi_sum  = {1'b0, in_chan.time_ns} + {1'b0, tol_r};
  assign hi_calc = hi_sum[tmb_pkg::STAMP_W] ? '1 : hi_sum[tmb_pkg::STAMP_W-1:0];

  // --------------------------------------------------------------------------
  // head compares and eviction test
  // --------------------------------------------------------------------------
  // Eviction when the store is full or one more would exceed max_entries.
  // A max_entries of zero acts as one; above DEPTH the store bound rules.
  assign evict = (count_r >= CW'(DEPTH)) ||
                 ((max_r == '0) ? (count_r != '0) : (LW'(count_r) >= LW'(max_r)));

  assign kept     = stamp_w[0] > time_r;
  assign in_win   = (stamp_w[0] >= lo_r) && (stamp_w[0] <= hi_r);
  assign count_m1 = count_r - 1'b1;

  // --------------------------------------------------------------------------
  // row control
  // Every scan step, and an add that evicts, pops the head by shifting the row
  // one cell towards index 0. Add writes the new entry at the tail; a scan pushes
  // the old head back at the tail (always for find, only if kept for remove), so
  // once every entry has passed the head the order is as before, minus the removed entries.
  // --------------------------------------------------------------------------
  always_comb begin
    shift    = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = '0;
    wr_stamp = time_r;
    wr_hnd   = hnd_r;
    unique case (state_r)
      ST_ADD: begin
        wr_en = 1'b1;
        if (evict) begin
          shift  = 1'b1;
          wr_idx = count_m1[IW-1:0];
        end else begin
          wr_idx = count_r[IW-1:0];
        end
      end
      ST_SCAN: begin
        shift    = 1'b1;
        wr_stamp = stamp_w[0];
        wr_hnd   = hnd_w[0];
        wr_idx   = count_m1[IW-1:0];
        wr_en    = (req_r == tmb_pkg::REQ_FIND) || kept;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [tmb_pkg::STAMP_W-1:0] nb_stamp;
    logic [HW-1:0]               nb_hnd;

    if (i == DEPTH - 1) begin : g_tail
      assign nb_stamp = '0;
      assign nb_hnd   = '0;
    end else begin : g_body
      assign nb_stamp = stamp_w[i+1];
      assign nb_hnd   = hnd_w[i+1];
    end

    assign ctrl_w[i].shift = shift;
    assign ctrl_w[i].wr    = wr_en && (wr_idx == IW'(i));

    tmb_cell #(
      .HW (HW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl_w[i]),
      .nb_stamp  (nb_stamp),
      .nb_handle (nb_hnd),
      .wr_stamp  (wr_stamp),
      .wr_handle (wr_hnd),
      .stamp     (stamp_w[i]),
      .handle    (hnd_w[i])
    );
  end

  // --------------------------------------------------------------------------
  // sequencer, result and configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      max_r       <= tmb_pkg::MAXE_RESET;
      tol_r       <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[tmb_pkg::ADDR_SEL_BIT])
          tmb_pkg::REG_MAX_ENTRIES: max_r <= pwdata[tmb_pkg::MAXE_W-1:0];
          tmb_pkg::REG_MATCH_TOL:   tol_r <= pwdata;
          default: begin
          end
        endcase
      end

      // in ST_DONE the output register is reloaded instead
      if (out_valid_r && out_chan.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            req_r     <= in_chan.req_type;
            time_r    <= in_chan.time_ns;
            hnd_r     <= in_chan.frame_handle[HW-1:0];
            lo_r      <= lo_calc;
            hi_r      <= hi_calc;
            scan_r    <= count_r;
            found_r   <= 1'b0;
            res_hnd_r <= '0;
            removed_r <= '0;
            unique case (in_chan.req_type) inside
              tmb_pkg::REQ_ADD: state_r <= ST_ADD;
              tmb_pkg::REQ_REMOVE,
              tmb_pkg::REQ_FIND: state_r <= (count_r != '0) ? ST_SCAN : ST_DONE;
              default:           state_r <= ST_DONE;   // unknown request: all-zero result
            endcase
          end
        end

        ST_ADD: begin
          if (evict) begin
            // oldest leaves, count stays
            found_r   <= 1'b1;
            res_hnd_r <= hnd_w[0];
          end else begin
            count_r <= count_r + 1'b1;
          end
          state_r <= ST_DONE;
        end

        ST_SCAN: begin
          scan_r <= scan_r - 1'b1;
          if (req_r == tmb_pkg::REQ_REMOVE) begin
            if (!kept) begin
              count_r   <= count_r - 1'b1;
              removed_r <= removed_r + 1'b1;
            end
          end else if (!found_r && in_win) begin
            // first hit is the oldest match
            found_r   <= 1'b1;
            res_hnd_r <= hnd_w[0];
          end
          if (scan_r == CW'(1)) begin
            state_r <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_hv_r    <= found_r;
            out_hnd_r   <= tmb_pkg::HANDLE_W'(res_hnd_r);
            out_rem_r   <= tmb_pkg::REMOVED_W'(removed_r);
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/tmb_cell.sv
// ----------------------------------------------------------------------------
// tmb_cell - one buffer slot
// Holds one stamp/handle pair; loads write data or takes its neighbour's entry.
// ----------------------------------------------------------------------------
module tmb_cell #(
  parameter int HW = 32
) (
  input  logic                         clk,
  input  tmb_pkg::cell_ctrl_t          ctrl,
  input  logic [tmb_pkg::STAMP_W-1:0]  nb_stamp,
  input  logic [HW-1:0]                nb_handle,
  input  logic [tmb_pkg::STAMP_W-1:0]  wr_stamp,
  input  logic [HW-1:0]                wr_handle,
  output logic [tmb_pkg::STAMP_W-1:0]  stamp,
  output logic [HW-1:0]                handle
);

  logic [tmb_pkg::STAMP_W-1:0] stamp_r;
  logic [HW-1:0]               handle_r;

  // write wins over shift
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      stamp_r  <= wr_stamp;
      handle_r <= wr_handle;
    end else if (ctrl.shift) begin
      stamp_r  <= nb_stamp;
      handle_r <= nb_handle;
    end
  end

  assign stamp  = stamp_r;
  assign handle = handle_r;

endmodule
